FILE: sv/ieval_pkg.sv
// Shared types and constants for the infix integer expression evaluator.
package ieval_pkg;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_OUTER = 3'd1,
    PH_INNER = 3'd2,
    PH_NUM   = 3'd3,
    PH_AFTER = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHAR,
    ST_ATOM,
    ST_MUL,
    ST_DIV,
    ST_RESUME,
    ST_LASTCHK,
    ST_FINAL
  } fsm_e;

  typedef enum logic [1:0] {
    TOP_NONE = 2'd0,
    TOP_MUL  = 2'd1,
    TOP_DIV  = 2'd2
  } term_op_e;

  typedef enum logic [1:0] {
    SGN_NONE  = 2'd0,
    SGN_PLUS  = 2'd1,
    SGN_MINUS = 2'd2
  } sign_e;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_DIV0   = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

FILE: sv/infix_integer_expression_evaluator_top.sv
// Streaming infix expression evaluator with a shared iterative multiply/divide unit.
//
//  channel | signals                         | transfer when
//  --------+---------------------------------+-----------------------------
//  in      | ch_i, is_last_i                 | in_valid_i & in_ready_o
//  out     | value_o, error_kind_o           | out_valid_o & out_ready_i
//
// Closing an atom under '*' or '/' iterates on the shared shift-add / restoring
// divide unit. On the is_last transfer, a text that ends in a number first closes
// that last atom, and then the result is formed.
// in_ready_o is high only in the idle state; a new result stalls until the
// previous one in the output register is taken.
// Reset clears all control and accumulator state; no clearing pass.
module infix_integer_expression_evaluator_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [1:0]  error_kind_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  ieval_pkg::fsm_e     state_q, state_d;
  ieval_pkg::phase_e   phase_q, phase_d;
  ieval_pkg::term_op_e top_q, top_d;
  ieval_pkg::sign_e    isgn_q, isgn_d;
  logic                oneg_q, oneg_d;
  logic                sneg_q, sneg_d;
  logic [1:0]          err_q, err_d;
  logic [W-1:0]        sum_q, sum_d;
  logic [W-1:0]        term_q, term_d;
  logic [W-1:0]        num_q, num_d;
  logic [7:0]          ch_q, ch_d;
  logic                last_q, last_d;
  logic                ctx_q, ctx_d;
  logic [W-1:0]        opa_q, opa_d;
  logic [W-1:0]        opb_q, opb_d;
  logic [W:0]          rem_q, rem_d;
  logic                qneg_q, qneg_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ovld_q, ovld_d;
  logic [W-1:0]        res_q, res_d;
  logic [1:0]          oerr_q, oerr_d;

  logic         is_ws, is_dig;
  logic [3:0]   dig;
  logic [W+3:0] acc10, lim;
  logic [W-1:0] atom_v, fold_v, mag_a, mag_b, mul_n, q_n;
  logic [W:0]   div_sh;
  logic         div_ge;
  logic [1:0]   err_fin;
  logic signed [W-1:0] res_s;

  assign is_ws  = (ch_q == ieval_pkg::CH_SPACE) ||
                  (ch_q >= ieval_pkg::CH_TAB && ch_q <= ieval_pkg::CH_CR);
  assign is_dig = (ch_q >= ieval_pkg::CH_ZERO) && (ch_q <= ieval_pkg::CH_NINE);
  assign dig    = 4'(ch_q - ieval_pkg::CH_ZERO);
  assign acc10  = {num_q, 3'b000} + {2'b00, num_q, 1'b0} + (W+4)'(dig);
  assign lim    = (W+4)'({1'b0, {(W-1){1'b1}}}) +
                  (W+4)'(isgn_q == ieval_pkg::SGN_MINUS);
  assign atom_v = ((isgn_q == ieval_pkg::SGN_MINUS) ^ oneg_q) ? (W'(0) - num_q) : num_q;
  assign fold_v = sneg_q ? (sum_q - term_q) : (sum_q + term_q);
  assign mag_a  = term_q[W-1] ? (W'(0) - term_q) : term_q;
  assign mag_b  = atom_v[W-1] ? (W'(0) - atom_v) : atom_v;
  assign mul_n  = opb_q[0] ? (rem_q[W-1:0] + opa_q) : rem_q[W-1:0];
  assign div_sh = {rem_q[W-1:0], opa_q[W-1]};
  assign div_ge = div_sh >= {1'b0, opb_q};
  assign q_n    = {opa_q[W-2:0], div_ge};
  assign err_fin = (err_q != ieval_pkg::ERR_NONE) ? err_q :
                   ((phase_q != ieval_pkg::PH_AFTER) ? ieval_pkg::ERR_SYNTAX
                                                      : ieval_pkg::ERR_NONE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    top_d   = top_q;
    isgn_d  = isgn_q;
    oneg_d  = oneg_q;
    sneg_d  = sneg_q;
    err_d   = err_q;
    sum_d   = sum_q;
    term_d  = term_q;
    num_d   = num_q;
    ch_d    = ch_q;
    last_d  = last_q;
    ctx_d   = ctx_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    rem_d   = rem_q;
    qneg_d  = qneg_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    oerr_d  = oerr_q;
    ovld_d  = ovld_q && !out_ready_i;
    in_ready_o = 1'b0;
    case (state_q)
      ieval_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d    = ch_i;
          last_d  = is_last_i;
          state_d = ieval_pkg::ST_CHAR;
        end
      end
      ieval_pkg::ST_CHAR: begin
        state_d = ieval_pkg::ST_LASTCHK;
        if (ch_q != ieval_pkg::CH_NUL && err_q == ieval_pkg::ERR_NONE) begin
          case (phase_q)
            ieval_pkg::PH_START: begin
              if (is_ws) begin
              end else if (ch_q == ieval_pkg::CH_MINUS) begin
                oneg_d  = 1'b1;
                phase_d = ieval_pkg::PH_OUTER;
              end else if (ch_q == ieval_pkg::CH_PLUS) begin
                isgn_d  = ieval_pkg::SGN_PLUS;
                phase_d = ieval_pkg::PH_INNER;
              end else if (is_dig) begin
                num_d   = W'(dig);
                phase_d = ieval_pkg::PH_NUM;
              end else begin
                err_d = ieval_pkg::ERR_SYNTAX;
              end
            end
            ieval_pkg::PH_OUTER: begin
              if (is_ws) begin
              end else if (ch_q == ieval_pkg::CH_MINUS || ch_q == ieval_pkg::CH_PLUS) begin
                isgn_d  = (ch_q == ieval_pkg::CH_MINUS) ? ieval_pkg::SGN_MINUS
                                                        : ieval_pkg::SGN_PLUS;
                phase_d = ieval_pkg::PH_INNER;
              end else if (is_dig) begin
                num_d   = W'(dig);
                phase_d = ieval_pkg::PH_NUM;
              end else begin
                err_d = ieval_pkg::ERR_SYNTAX;
              end
            end
            ieval_pkg::PH_INNER: begin
              if (is_dig) begin
                num_d   = W'(dig);
                phase_d = ieval_pkg::PH_NUM;
              end else begin
                err_d = ieval_pkg::ERR_SYNTAX;
              end
            end
            ieval_pkg::PH_NUM: begin
              if (is_dig) begin
                if (acc10 > lim) err_d = ieval_pkg::ERR_SYNTAX;
                else num_d = acc10[W-1:0];
              end else begin
                ctx_d   = 1'b0;
                state_d = ieval_pkg::ST_ATOM;
              end
            end
            ieval_pkg::PH_AFTER: begin
              if (!is_ws) begin
                ctx_d   = 1'b0;
                state_d = ieval_pkg::ST_RESUME;
              end
            end
            default: err_d = ieval_pkg::ERR_SYNTAX;
          endcase
        end
      end
      ieval_pkg::ST_ATOM: begin
        opa_d  = mag_a;
        opb_d  = mag_b;
        rem_d  = '0;
        cnt_d  = '0;
        qneg_d = term_q[W-1] ^ atom_v[W-1];
        case (top_q)
          ieval_pkg::TOP_MUL: begin
            opa_d   = term_q;
            opb_d   = atom_v;
            state_d = ieval_pkg::ST_MUL;
          end
          ieval_pkg::TOP_DIV: begin
            if (atom_v == '0) begin
              err_d   = ieval_pkg::ERR_DIV0;
              state_d = ieval_pkg::ST_RESUME;
            end else begin
              state_d = ieval_pkg::ST_DIV;
            end
          end
          default: begin
            term_d  = atom_v;
            phase_d = ieval_pkg::PH_AFTER;
            state_d = ieval_pkg::ST_RESUME;
          end
        endcase
      end
      ieval_pkg::ST_MUL: begin
        rem_d = {1'b0, mul_n};
        opa_d = {opa_q[W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[W-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          term_d  = mul_n;
          phase_d = ieval_pkg::PH_AFTER;
          state_d = ieval_pkg::ST_RESUME;
        end
      end
      ieval_pkg::ST_DIV: begin
        rem_d = div_ge ? (div_sh - {1'b0, opb_q}) : div_sh;
        opa_d = q_n;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          term_d  = qneg_q ? (W'(0) - q_n) : q_n;
          phase_d = ieval_pkg::PH_AFTER;
          state_d = ieval_pkg::ST_RESUME;
        end
      end
      ieval_pkg::ST_RESUME: begin
        state_d = ieval_pkg::ST_LASTCHK;
        if (!ctx_q && err_q == ieval_pkg::ERR_NONE && !is_ws) begin
          if (ch_q == ieval_pkg::CH_PLUS || ch_q == ieval_pkg::CH_MINUS) begin
            sum_d  = fold_v;
            sneg_d = (ch_q == ieval_pkg::CH_MINUS);
            top_d  = ieval_pkg::TOP_NONE;
          end else if (ch_q == ieval_pkg::CH_STAR) begin
            top_d = ieval_pkg::TOP_MUL;
          end else if (ch_q == ieval_pkg::CH_SLASH) begin
            top_d = ieval_pkg::TOP_DIV;
          end else begin
            err_d = ieval_pkg::ERR_SYNTAX;
          end
          if (ch_q == ieval_pkg::CH_PLUS || ch_q == ieval_pkg::CH_MINUS ||
              ch_q == ieval_pkg::CH_STAR || ch_q == ieval_pkg::CH_SLASH) begin
            oneg_d  = 1'b0;
            isgn_d  = ieval_pkg::SGN_NONE;
            num_d   = '0;
            phase_d = ieval_pkg::PH_START;
          end
        end
      end
      ieval_pkg::ST_LASTCHK: begin
        if (!last_q) begin
          state_d = ieval_pkg::ST_IDLE;
        end else if (err_q == ieval_pkg::ERR_NONE && phase_q == ieval_pkg::PH_NUM) begin
          ctx_d   = 1'b1;
          state_d = ieval_pkg::ST_ATOM;
        end else begin
          state_d = ieval_pkg::ST_FINAL;
        end
      end
      ieval_pkg::ST_FINAL: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          oerr_d  = err_fin;
          res_d   = (err_fin == ieval_pkg::ERR_NONE) ? fold_v : '0;
          sum_d   = '0;
          sneg_d  = 1'b0;
          term_d  = '0;
          top_d   = ieval_pkg::TOP_NONE;
          num_d   = '0;
          oneg_d  = 1'b0;
          isgn_d  = ieval_pkg::SGN_NONE;
          phase_d = ieval_pkg::PH_START;
          err_d   = ieval_pkg::ERR_NONE;
          state_d = ieval_pkg::ST_IDLE;
        end
      end
      default: state_d = ieval_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ieval_pkg::ST_IDLE;
      phase_q <= ieval_pkg::PH_START;
      top_q   <= ieval_pkg::TOP_NONE;
      isgn_q  <= ieval_pkg::SGN_NONE;
      oneg_q  <= 1'b0;
      sneg_q  <= 1'b0;
      err_q   <= ieval_pkg::ERR_NONE;
      sum_q   <= '0;
      term_q  <= '0;
      num_q   <= '0;
      ctx_q   <= 1'b0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      top_q   <= top_d;
      isgn_q  <= isgn_d;
      oneg_q  <= oneg_d;
      sneg_q  <= sneg_d;
      err_q   <= err_d;
      sum_q   <= sum_d;
      term_q  <= term_d;
      num_q   <= num_d;
      ctx_q   <= ctx_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    rem_q  <= rem_d;
    qneg_q <= qneg_d;
    res_q  <= res_d;
    oerr_q <= oerr_d;
  end

  assign res_s        = res_q;
  assign value_o      = 64'(res_s);
  assign error_kind_o = oerr_q;
  assign out_valid_o  = ovld_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_kind_o != ieval_pkg::ERR_NONE) |-> value_o == 64'd0)
    else $error("errored result carries a nonzero value");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_kind_o != 2'd3)
    else $error("undefined error code");

  a_iter_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ieval_pkg::ST_MUL || state_q == ieval_pkg::ST_DIV) |-> cnt_q < CW'(W))
    else $error("iteration count overrun");

  a_final_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ieval_pkg::ST_FINAL && out_valid_o && !out_ready_i) |=>
      state_q == ieval_pkg::ST_FINAL)
    else $error("result dropped while output stalled");

endmodule
